// File: sv/prince_like_block_cipher_macros.svh
// Assertion helpers for the checker file.
`ifndef PRINCE_LIKE_BLOCK_CIPHER_MACROS_SVH
`define PRINCE_LIKE_BLOCK_CIPHER_MACROS_SVH

// Checked only out of reset.
`define PLBC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked in every cycle, reset included.
`define PLBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/plbc_pkg.sv
package plbc_pkg;

    localparam int NUM_STAGES = 11;

    localparam logic [63:0] CORE_KEY = 64'h4341_5241_4C41_4355;

    localparam logic [3:0] SBOX_FWD [16] = '{
        4'h4, 4'h7, 4'h2, 4'h1, 4'h8, 4'hB, 4'hE, 4'hD,
        4'hF, 4'hC, 4'h9, 4'hA, 4'h3, 4'h0, 4'h5, 4'h6
    };

    localparam logic [3:0] SBOX_INV [16] = '{
        4'hD, 4'h3, 4'h2, 4'hC, 4'h0, 4'hE, 4'hF, 4'h1,
        4'h4, 4'hA, 4'hB, 4'h5, 4'h9, 4'h7, 4'h6, 4'h8
    };

    localparam logic [63:0] ROUND_CONST [12] = '{
        64'h0000000000000000, 64'h13198A2E03707344,
        64'hA4093822299F31D0, 64'h082EFA98EC4E6C89,
        64'h452821E638D01377, 64'hBE5466CF34E90C6C,
        64'h7EF84F78FD955CB1, 64'h85840851F1AC43AA,
        64'hC882D32F25323C54, 64'h64A51195E0E3610D,
        64'hD3B5A399CA0C2399, 64'hC0AC29B7C97C50DD
    };

    typedef enum logic {
        FUNC_ENCRYPT = 1'b0,
        FUNC_DECRYPT = 1'b1
    } func_t;

    function automatic logic [63:0] sub_nibbles(input logic [63:0] x, input logic inv);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            r[4*i +: 4] = inv ? SBOX_INV[x[4*i +: 4]] : SBOX_FWD[x[4*i +: 4]];
        end
        return r;
    endfunction

    // out nibble i = in nibble (add + mul*i) mod 16
    function automatic logic [63:0] permute_nibbles(input logic [63:0] x,
                                                    input int mul, input int add);
        logic [63:0] r;
        logic [3:0]  src;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            src = 4'(add + mul * i);
            r[4*i +: 4] = x[4*src +: 4];
        end
        return r;
    endfunction

    function automatic logic [15:0] mix16(input logic [15:0] x, input int off);
        logic [15:0] r;
        logic        p;
        logic [1:0]  e;
        r = '0;
        for (int j = 0; j < 4; j++) begin
            p = x[j] ^ x[4+j] ^ x[8+j] ^ x[12+j];
            for (int g = 0; g < 4; g++) begin
                e = 2'(j + 4 - g + off);
                r[4*g + j] = p ^ x[4*e + j];
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] mprime(input logic [63:0] x);
        return {mix16(x[63:48], 3), mix16(x[47:32], 0),
                mix16(x[31:16], 0), mix16(x[15:0], 3)};
    endfunction

    function automatic logic [63:0] derived_key(input logic [63:0] k0);
        return {k0[0], k0[63:1]} ^ {63'b0, k0[63]};
    endfunction

    // Round at position pos (1..5) before the middle layer.
    function automatic logic [63:0] fwd_round(input logic [63:0] x, input logic dec,
                                              input int pos);
        logic [63:0] s;
        s = mprime(sub_nibbles(x, 1'b0));
        s = permute_nibbles(s, 5, dec ? 2 : 14);
        return s ^ CORE_KEY ^ ROUND_CONST[dec ? 11 - pos : pos];
    endfunction

    function automatic logic [63:0] middle_layer(input logic [63:0] x);
        return sub_nibbles(mprime(sub_nibbles(x, 1'b0)), 1'b1);
    endfunction

    // Round at position pos (6..10) after the middle layer.
    function automatic logic [63:0] bwd_round(input logic [63:0] x, input logic dec,
                                              input int pos);
        logic [63:0] s;
        s = x ^ CORE_KEY ^ ROUND_CONST[dec ? 11 - pos : pos];
        s = permute_nibbles(s, 13, dec ? 10 : 6);
        return sub_nibbles(mprime(s), 1'b1);
    endfunction

endpackage

// File: sv/prince_like_block_cipher.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: block_in; tuser: func
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: block_out
// apb       in   psel, penable, pwrite, pready  64-bit whitening key at address 0
//
// Eleven register stages: five forward rounds (the first with input whitening),
// the middle layer, five backward rounds (the last with output whitening).
// One block per clock while the output is not stalled.
// Each stage holds its request while the next one is full and stalled, so
// bubbles are squeezed out and nothing is dropped or repeated.
// aresetn clears the stage valid bits and the key register.
module prince_like_block_cipher
    import plbc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] block_in
    input  logic [0:0]  s_axis_tuser,   // [0] func

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] block_out

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [63:0] key_reg;
    logic [63:0] key_in;     // k0 ^ k1
    logic [63:0] key_out;    // k0' ^ k1 ^ alpha

    logic [63:0] data_reg  [NUM_STAGES];
    logic [63:0] data_next [NUM_STAGES];
    logic        func_reg  [NUM_STAGES];
    logic        valid_reg [NUM_STAGES];
    logic        ready     [NUM_STAGES + 1];

    // register index is paddr[3]; only index 0 exists
    assign pready = 1'b1;
    assign prdata = paddr[3] ? 64'd0 : key_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (psel && penable && pwrite && !paddr[3]) begin
            key_reg <= pwdata;
        end
    end

    assign key_in  = key_reg ^ CORE_KEY;
    assign key_out = derived_key(key_reg) ^ CORE_KEY ^ ROUND_CONST[11];

    assign ready[NUM_STAGES] = m_axis_tready;
    assign s_axis_tready     = ready[0];
    assign m_axis_tvalid     = valid_reg[NUM_STAGES - 1];
    assign m_axis_tdata      = data_reg[NUM_STAGES - 1];

    for (genvar st = 0; st < NUM_STAGES; st++) begin : g_stage
        logic        valid_in;
        logic        func_in;
        logic [63:0] data_in;

        if (st == 0) begin : g_first
            assign valid_in = s_axis_tvalid;
            assign func_in  = s_axis_tuser[0];
            assign data_in  = s_axis_tdata ^
                              ((s_axis_tuser[0] == FUNC_DECRYPT) ? key_out : key_in);
        end else begin : g_mid
            assign valid_in = valid_reg[st - 1];
            assign func_in  = func_reg[st - 1];
            assign data_in  = data_reg[st - 1];
        end

        if (st < 5) begin : g_fwd
            assign data_next[st] = fwd_round(data_in, func_in, st + 1);
        end else if (st == 5) begin : g_middle
            assign data_next[st] = middle_layer(data_in);
        end else if (st < NUM_STAGES - 1) begin : g_bwd
            assign data_next[st] = bwd_round(data_in, func_in, st);
        end else begin : g_last
            assign data_next[st] = bwd_round(data_in, func_in, st) ^
                                   ((func_in == FUNC_DECRYPT) ? key_in : key_out);
        end

        assign ready[st] = !valid_reg[st] || ready[st + 1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[st] <= 1'b0;
            end else if (ready[st]) begin
                valid_reg[st] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ready[st] && valid_in) begin
                data_reg[st] <= data_next[st];
                func_reg[st] <= func_in;
            end
        end
    end

endmodule

// File: sv/plbc_checker.sv
`include "prince_like_block_cipher_macros.svh"

module plbc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [63:0] s_axis_tdata,
    input logic [0:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [63:0] pwdata,
    input logic [63:0] prdata,
    input logic        pready
);

    logic key_write;
    assign key_write = psel && penable && pwrite && pready && !paddr[3];

    // stalled result must hold
    `PLBC_ASSERT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // an empty or draining output stage lets the whole pipe move
    `PLBC_ASSERT(a_in_ready, aclk, aresetn, (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready, "input held off with output free")

    // reset empties the pipe
    `PLBC_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_axis_tvalid, "result valid after reset")

    // key readback follows the last write
    `PLBC_ASSERT(a_key_readback, aclk, aresetn, key_write |=> (paddr[3] || prdata == $past(pwdata)), "key readback mismatch")

endmodule

bind prince_like_block_cipher plbc_checker u_plbc_checker (.*);
